[sv/bdeq_pkg.sv]
`timescale 1ns / 1ps

package bdeq_pkg;

  // Defaults for the top-level parameters
  localparam int BUTTONS_DEFAULT     = 6;
  localparam int QUEUE_DEPTH_DEFAULT = 16;

  // Fixed field widths
  localparam int FUNC_W    = 2;
  localparam int RAW_W     = 6;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 3;
  localparam int KIND_W    = 2;
  localparam int MASK_W    = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd2;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LONG    = 2'd3;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INIT,
    OP_DEB,
    OP_LONG,
    OP_PUSH,
    OP_NEXT,
    OP_LOAD_PLAIN,
    OP_LOAD_POP
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic ev_pending;
    logic btn_last;
    logic out_full;
  } dp_status_t;

endpackage

[sv/button_debounce_event_queue_top.sv]
`timescale 1ns / 1ps

// Button debouncer with long-press detection and an event ring.
// Input channel (in_valid/in_ready): one word per command. func selects
// poll (sample raw_levels at current_time), pop (take the oldest event)
// or init (load raw levels as stable, clear the ring). Unused func codes
// change nothing but still return a word.
// Output channel (out_valid/out_ready): exactly one word per input word,
// in order. event_valid marks a popped event; pressed_mask always shows the
// stable pressed buttons after the command.
// For a poll, the per-button sequencer walks the buttons one at a time
// and the event memory takes one push per cycle. One command is in
// flight at a time; in_ready returns the cycle after the result is
// loaded into the output register.
// A stalled receiver holds the output register; the next command is still
// accepted and runs up to its final load, where it waits.
// Reset (rst, synchronous) restores debounce 20 ms, long press 1000 ms,
// active-low buttons, clears all button state and empties the ring.
// Write config only while idle: cfg_we with cfg_index 0 debounce time,
// 1 long-press time, 2 active level.

module button_debounce_event_queue_top import bdeq_pkg::*; #(
  parameter int BUTTONS     = BUTTONS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [RAW_W-1:0]     raw_levels,
  input  logic [TIME_W-1:0]    current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 event_valid,
  output logic [IDX_W-1:0]     button_index,
  output logic [KIND_W-1:0]    event_kind,
  output logic [TIME_W-1:0]    event_time,
  output logic [TIME_W-1:0]    hold_time,
  output logic [MASK_W-1:0]    pressed_mask
);

  dp_op_t     cmd;
  dp_status_t status;

  // Sequencer: walks buttons, drains staged events into the ring
  bdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .status   (status),
    .cmd      (cmd)
  );

  // Button state, event ring and output register
  bdeq_datapath #(
    .BUTTONS     (BUTTONS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_levels   (raw_levels),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_valid  (event_valid),
    .button_index (button_index),
    .event_kind   (event_kind),
    .event_time   (event_time),
    .hold_time    (hold_time),
    .pressed_mask (pressed_mask)
  );

endmodule

[sv/bdeq_ctrl.sv]
`timescale 1ns / 1ps

module bdeq_ctrl import bdeq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  dp_status_t        status,
  output dp_op_t            cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INIT      = 9'b000000010,
    S_DEB       = 9'b000000100,
    S_DEB_PUSH  = 9'b000001000,
    S_LONG      = 9'b000010000,
    S_LONG_PUSH = 9'b000100000,
    S_POP_RD    = 9'b001000000,
    S_POP_OUT   = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = OP_CAPTURE;
          unique case (func)
            FUNC_POLL: state_next = S_DEB;
            FUNC_POP:  state_next = S_POP_RD;
            FUNC_INIT: state_next = S_INIT;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        cmd        = OP_INIT;
        state_next = S_DONE;
      end
      S_DEB: begin
        cmd        = OP_DEB;
        state_next = S_DEB_PUSH;
      end
      S_DEB_PUSH: begin
        if (status.ev_pending) begin
          cmd = OP_PUSH;
        end else begin
          state_next = S_LONG;
        end
      end
      S_LONG: begin
        cmd        = OP_LONG;
        state_next = S_LONG_PUSH;
      end
      S_LONG_PUSH: begin
        if (status.ev_pending) begin
          cmd = OP_PUSH;
        end else if (status.btn_last) begin
          state_next = S_DONE;
        end else begin
          cmd        = OP_NEXT;
          state_next = S_DEB;
        end
      end
      // memory read data lands at the end of this cycle
      S_POP_RD: begin
        state_next = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (!status.out_full) begin
          cmd        = OP_LOAD_POP;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd        = OP_LOAD_PLAIN;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/bdeq_datapath.sv]
`timescale 1ns / 1ps

module bdeq_datapath import bdeq_pkg::*; #(
  parameter int BUTTONS     = BUTTONS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_op_t               cmd,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [RAW_W-1:0]     raw_levels,
  input  logic [TIME_W-1:0]    current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 event_valid,
  output logic [IDX_W-1:0]     button_index,
  output logic [KIND_W-1:0]    event_kind,
  output logic [TIME_W-1:0]    event_time,
  output logic [TIME_W-1:0]    hold_time,
  output logic [MASK_W-1:0]    pressed_mask
);

  localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int RAWX_W  = (BUTTONS > RAW_W) ? BUTTONS : RAW_W;
  localparam int ENTRY_W = IDX_W + KIND_W + 2 * TIME_W;

  // Configuration
  logic [CFG_W-1:0] debounce_time;
  logic [CFG_W-1:0] long_press_time;
  logic             active_level;

  // Captured input word
  logic [RAW_W-1:0]  raw_q;
  logic [TIME_W-1:0] now_q;

  // Per-button state
  logic [BUTTONS-1:0] sampled;
  logic [BUTTONS-1:0] stable;
  logic [BUTTONS-1:0] pending;
  logic [BUTTONS-1:0] long_rep;
  logic [TIME_W-1:0]  deadline    [BUTTONS];
  logic [TIME_W-1:0]  press_start [BUTTONS];
  logic [BTN_W-1:0]   btn;

  // Events waiting to be pushed
  logic [1:0]        ev_count;
  logic [KIND_W-1:0] ev0_kind;
  logic [KIND_W-1:0] ev1_kind;
  logic [TIME_W-1:0] ev0_hold;
  logic [TIME_W-1:0] ev1_hold;
  logic [TIME_W-1:0] held_q;

  // Event ring
  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   rp;
  logic [PTR_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   rp_inc;
  logic               q_empty;

  logic               out_full;

  // Per-button step signals
  logic [RAWX_W-1:0]  raw_pad;
  logic [BUTTONS-1:0] press_now;
  logic               cur_press;
  logic               changed;
  logic [TIME_W-1:0]  dl_sum;
  logic [TIME_W-1:0]  dl_diff;
  logic [TIME_W-1:0]  hold_diff;
  logic [TIME_W-1:0]  long_diff;
  logic               due;
  logic               pend_a;
  logic               fire;
  logic               flip;
  logic               long_hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Buttons past the raw field read level 0
  assign raw_pad   = RAWX_W'(raw_q);
  assign press_now = ~(raw_pad[BUTTONS-1:0] ^ {BUTTONS{active_level}});

  assign cur_press = press_now[btn];
  assign changed   = cur_press != sampled[btn];
  assign dl_sum    = now_q + TIME_W'(debounce_time);
  assign dl_diff   = now_q - deadline[btn];
  assign hold_diff = now_q - press_start[btn];
  // a fresh deadline is already due only for a zero debounce time
  assign due       = changed ? (debounce_time == '0) : ~dl_diff[TIME_W-1];
  assign pend_a    = changed | pending[btn];
  assign fire      = pend_a & due;
  assign flip      = fire & (stable[btn] != cur_press);

  assign long_diff = held_q - TIME_W'(long_press_time);
  assign long_hit  = stable[btn] & ~long_rep[btn] & ~long_diff[TIME_W-1];

  assign wp_inc  = ptr_inc(wp);
  assign rp_inc  = ptr_inc(rp);
  assign q_empty = (rp == wp);

  assign status.ev_pending = (ev_count != 2'd0);
  assign status.btn_last   = (btn == BTN_W'(BUTTONS - 1));
  assign status.out_full   = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
      active_level    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_time   <= cfg_data;
        CFG_LONG_PRESS: long_press_time <= cfg_data;
        CFG_ACTIVE:     active_level    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == OP_CAPTURE) begin
      raw_q <= raw_levels;
      now_q <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn <= '0;
    end else if (cmd == OP_CAPTURE) begin
      btn <= '0;
    end else if (cmd == OP_NEXT) begin
      btn <= btn + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sampled  <= '0;
      stable   <= '0;
      pending  <= '0;
      long_rep <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        deadline[i]    <= '0;
        press_start[i] <= '0;
      end
    end else begin
      case (cmd)
        OP_INIT: begin
          sampled  <= press_now;
          stable   <= press_now;
          pending  <= '0;
          long_rep <= '0;
          for (int i = 0; i < BUTTONS; i++) begin
            deadline[i]    <= '0;
            press_start[i] <= now_q;
          end
        end
        OP_DEB: begin
          sampled[btn] <= cur_press;
          pending[btn] <= pend_a & ~due;
          if (changed) begin
            deadline[btn] <= dl_sum;
          end
          if (flip) begin
            stable[btn] <= cur_press;
            if (cur_press) begin
              press_start[btn] <= now_q;
              long_rep[btn]    <= 1'b0;
            end
          end
        end
        OP_LONG: begin
          if (long_hit) begin
            long_rep[btn] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Stage events for the push loop; hold time after this step goes to held_q
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_count <= 2'd0;
    end else begin
      case (cmd)
        OP_DEB: begin
          if (flip && cur_press) begin
            ev_count <= 2'd1;
          end else if (flip) begin
            ev_count <= long_rep[btn] ? 2'd1 : 2'd2;
          end else begin
            ev_count <= 2'd0;
          end
        end
        OP_LONG: ev_count <= long_hit ? 2'd1 : 2'd0;
        OP_PUSH: ev_count <= ev_count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      OP_DEB: begin
        held_q   <= (flip && cur_press) ? '0 : hold_diff;
        ev0_kind <= cur_press ? KIND_PRESS : KIND_RELEASE;
        ev0_hold <= cur_press ? '0 : hold_diff;
        ev1_kind <= KIND_SHORT;
        ev1_hold <= hold_diff;
      end
      OP_LONG: begin
        ev0_kind <= KIND_LONG;
        ev0_hold <= held_q;
      end
      OP_PUSH: begin
        ev0_kind <= ev1_kind;
        ev0_hold <= ev1_hold;
      end
      default: ;
    endcase
  end

  // Ring pointers; a push into a full ring drops the oldest entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      case (cmd)
        OP_INIT: begin
          wp <= '0;
          rp <= '0;
        end
        OP_PUSH: begin
          wp <= wp_inc;
          if (wp_inc == rp) begin
            rp <= rp_inc;
          end
        end
        OP_LOAD_POP: begin
          if (!q_empty) begin
            rp <= rp_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == OP_PUSH) begin
      mem[wp] <= {IDX_W'(btn), ev0_kind, now_q, ev0_hold};
    end
    rd_data <= mem[rp];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd == OP_LOAD_PLAIN || cmd == OP_LOAD_POP) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == OP_LOAD_PLAIN || cmd == OP_LOAD_POP) begin
      pressed_mask <= MASK_W'(stable);
      if (cmd == OP_LOAD_POP && !q_empty) begin
        event_valid  <= 1'b1;
        button_index <= rd_data[ENTRY_W-1 -: IDX_W];
        event_kind   <= rd_data[2*TIME_W +: KIND_W];
        event_time   <= rd_data[TIME_W +: TIME_W];
        hold_time    <= rd_data[TIME_W-1:0];
      end else begin
        event_valid  <= 1'b0;
        button_index <= '0;
        event_kind   <= KIND_PRESS;
        event_time   <= '0;
        hold_time    <= '0;
      end
    end
  end

  assign out_valid = out_full;

endmodule
